// ===== rtl/i2cm_pkg.sv =====
package i2cm_pkg;

    typedef enum logic [2:0] {
        REQ_NONE  = 3'd0,
        REQ_START = 3'd1,
        REQ_STOP  = 3'd2,
        REQ_WRITE = 3'd3,
        REQ_READ  = 3'd4,
        REQ_ACK   = 3'd5,
        REQ_NACK  = 3'd6,
        REQ_RSVD  = 3'd7
    } req_t;

    typedef enum logic [20:0] {
        ST_IDLE    = 21'h000001,
        ST_S_SCLH  = 21'h000002,
        ST_S_W1    = 21'h000004,
        ST_S_W2    = 21'h000008,
        ST_S_W3    = 21'h000010,
        ST_P_SCLH  = 21'h000020,
        ST_P_W1    = 21'h000040,
        ST_P_W2    = 21'h000080,
        ST_W_SCLH  = 21'h000100,
        ST_W_HI    = 21'h000200,
        ST_W_LO    = 21'h000400,
        ST_W_ASCLH = 21'h000800,
        ST_W_AHI   = 21'h001000,
        ST_W_ALO   = 21'h002000,
        ST_R_SCLH  = 21'h004000,
        ST_R_LO    = 21'h008000,
        ST_K_W0    = 21'h010000,
        ST_K_W1    = 21'h020000,
        ST_K_SCLH  = 21'h040000,
        ST_K_HI    = 21'h080000,
        ST_K_LO    = 21'h100000
    } step_t;

    localparam logic [15:0] DELAY_RESET = 16'd133;
    localparam logic [3:0]  BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic       ack_bit;
        logic [7:0] read_byte;
        logic       done_res;
        logic       ready_res;
        logic       sda_pull_low;
        logic       scl_pull_low;
    } result_t;

endpackage

// ===== rtl/i2c_master_bit_sequencer.sv =====
// I2C master bit sequencer. Each input item is one bus tick carrying the sampled
// SCL/SDA levels and, when the block reports ready, a command (start, stop, write
// byte, read byte, ack, nack). Every input item yields exactly one result item with
// the pull-low drives, ready, a done pulse, the last read byte and the last ack bit.
// One item is taken per clock while s_tready is high and advances the sequencer state;
// its result is registered in the result register, or in the skid register while the
// output is held. A two-entry output stage (result register plus skid register) keeps
// s_tready high in the cycle m_tready first drops; while the skid register holds an
// item s_tready is low, and rises again the cycle after the downstream side takes one.
// delay_ticks (cfg_wr_data, reset 133) sets the length of every bus wait in ticks.
module i2c_master_bit_sequencer
    import i2cm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,   // delay_ticks
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,       // write_data[7:0], scl_in[8], sda_in[9], zero
    input  logic [2:0]  s_tuser,       // req_type[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata        // scl_pull_low[0], sda_pull_low[1], ready_res[2],
                                       // done_res[3], read_byte[11:4], ack_bit[12], zero
);

    logic [15:0] delay_ticks_reg;
    logic        accept;
    logic        pop;
    result_t     result;
    logic        out_valid_reg;
    result_t     out_data_reg;
    logic        skid_valid_reg;
    result_t     skid_data_reg;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_ticks_reg <= DELAY_RESET;
        end else if (cfg_wr_en) begin
            delay_ticks_reg <= cfg_wr_data;
        end
    end

    i2cm_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .tick_en     (accept),
        .req_type    (s_tuser),
        .write_data  (s_tdata[7:0]),
        .scl_in      (s_tdata[8]),
        .sda_in      (s_tdata[9]),
        .delay_ticks (delay_ticks_reg),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                // output still held: park the new item in the skid slot
                if (out_valid_reg && !m_tready) begin
                    skid_valid_reg <= 1'b1;
                end else begin
                    out_valid_reg <= 1'b1;
                end
            end else if (pop) begin
                out_valid_reg  <= skid_valid_reg;
                skid_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            if (out_valid_reg && !m_tready) begin
                skid_data_reg <= result;
            end else begin
                out_data_reg <= result;
            end
        end else if (pop && skid_valid_reg) begin
            out_data_reg <= skid_data_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_data_reg};

endmodule

// ===== rtl/i2cm_core.sv =====
module i2cm_core
    import i2cm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        tick_en,
    input  logic [2:0]  req_type,
    input  logic [7:0]  write_data,
    input  logic        scl_in,
    input  logic        sda_in,
    input  logic [15:0] delay_ticks,
    output result_t     result
);

    step_t       step_reg, step_next;
    logic [3:0]  bit_index_reg, bit_index_next;
    logic [7:0]  shift_byte_reg, shift_byte_next;
    logic [15:0] wait_counter_reg, wait_counter_next;
    logic        scl_drive_reg, scl_drive_next;
    logic        sda_drive_reg, sda_drive_next;
    logic [7:0]  received_byte_reg, received_byte_next;
    logic        ack_store_reg, ack_store_next;

    logic        wait_done;
    logic [15:0] wait_dec;
    logic [3:0]  bit_inc;
    logic        done;

    // a zero or one count ends the wait on this tick
    assign wait_done = (wait_counter_reg <= 16'd1);
    assign wait_dec  = wait_counter_reg - 16'd1;
    assign bit_inc   = bit_index_reg + 4'd1;

    always_comb begin
        step_next          = step_reg;
        bit_index_next     = bit_index_reg;
        shift_byte_next    = shift_byte_reg;
        wait_counter_next  = wait_counter_reg;
        scl_drive_next     = scl_drive_reg;
        sda_drive_next     = sda_drive_reg;
        received_byte_next = received_byte_reg;
        ack_store_next     = ack_store_reg;
        done               = 1'b0;

        case (step_reg)
            ST_IDLE: begin
                case (req_t'(req_type))
                    REQ_START: begin
                        if (scl_in) scl_drive_next = 1'b1;
                        sda_drive_next = 1'b0;
                        step_next      = ST_S_SCLH;
                    end
                    REQ_STOP: begin
                        if (scl_in) scl_drive_next = 1'b1;
                        sda_drive_next = 1'b1;
                        step_next      = ST_P_SCLH;
                    end
                    REQ_WRITE: begin
                        bit_index_next  = 4'd0;
                        sda_drive_next  = ~write_data[7];
                        shift_byte_next = {write_data[6:0], 1'b0};
                        step_next       = ST_W_SCLH;
                    end
                    REQ_READ: begin
                        sda_drive_next  = 1'b0;
                        bit_index_next  = 4'd0;
                        shift_byte_next = 8'd0;
                        step_next       = ST_R_SCLH;
                    end
                    REQ_ACK: begin
                        sda_drive_next    = 1'b1;
                        wait_counter_next = delay_ticks;
                        step_next         = ST_K_W0;
                    end
                    REQ_NACK: begin
                        sda_drive_next    = 1'b0;
                        wait_counter_next = delay_ticks;
                        step_next         = ST_K_W0;
                    end
                    default: begin
                    end
                endcase
            end
            ST_S_SCLH, ST_P_SCLH, ST_W_SCLH, ST_W_ASCLH, ST_K_SCLH: begin
                scl_drive_next = 1'b0;
                if (scl_in) begin
                    wait_counter_next = delay_ticks;
                    case (step_reg)
                        ST_S_SCLH:  step_next = ST_S_W1;
                        ST_P_SCLH:  step_next = ST_P_W1;
                        ST_W_SCLH:  step_next = ST_W_HI;
                        ST_W_ASCLH: step_next = ST_W_AHI;
                        default:    step_next = ST_K_HI;
                    endcase
                end
            end
            ST_R_SCLH: begin
                scl_drive_next = 1'b0;
                // sample on the first tick SCL reads high, then pull low again
                if (scl_in) begin
                    shift_byte_next   = {shift_byte_reg[6:0], sda_in};
                    scl_drive_next    = 1'b1;
                    wait_counter_next = delay_ticks;
                    step_next         = ST_R_LO;
                end
            end
            default: begin
                if (!wait_done) begin
                    wait_counter_next = wait_dec;
                end else begin
                    case (step_reg)
                        ST_S_W1: begin
                            sda_drive_next    = 1'b1;
                            wait_counter_next = delay_ticks;
                            step_next         = ST_S_W2;
                        end
                        ST_S_W2: begin
                            scl_drive_next    = 1'b1;
                            wait_counter_next = delay_ticks;
                            step_next         = ST_S_W3;
                        end
                        ST_P_W1: begin
                            sda_drive_next    = 1'b0;
                            wait_counter_next = delay_ticks;
                            step_next         = ST_P_W2;
                        end
                        ST_W_HI, ST_K_HI: begin
                            scl_drive_next    = 1'b1;
                            wait_counter_next = delay_ticks;
                            step_next         = (step_reg == ST_W_HI) ? ST_W_LO : ST_K_LO;
                        end
                        ST_W_LO: begin
                            bit_index_next = bit_inc;
                            if (bit_inc < BITS_PER_BYTE) begin
                                sda_drive_next  = ~shift_byte_reg[7];
                                shift_byte_next = {shift_byte_reg[6:0], 1'b0};
                                step_next       = ST_W_SCLH;
                            end else begin
                                sda_drive_next = 1'b0;
                                step_next      = ST_W_ASCLH;
                            end
                        end
                        ST_W_AHI: begin
                            ack_store_next    = sda_in;
                            scl_drive_next    = 1'b1;
                            wait_counter_next = delay_ticks;
                            step_next         = ST_W_ALO;
                        end
                        ST_R_LO: begin
                            bit_index_next = bit_inc;
                            if (bit_inc < BITS_PER_BYTE) begin
                                step_next = ST_R_SCLH;
                            end else begin
                                received_byte_next = shift_byte_reg;
                                step_next          = ST_IDLE;
                                done               = 1'b1;
                            end
                        end
                        ST_K_W0: begin
                            wait_counter_next = delay_ticks;
                            step_next         = ST_K_W1;
                        end
                        ST_K_W1: begin
                            step_next = ST_K_SCLH;
                        end
                        ST_S_W3, ST_P_W2, ST_W_ALO, ST_K_LO: begin
                            step_next = ST_IDLE;
                            done      = 1'b1;
                        end
                        default: begin
                            step_next = ST_IDLE;
                        end
                    endcase
                end
            end
        endcase
    end

    always_comb begin
        result.scl_pull_low = scl_drive_next;
        result.sda_pull_low = sda_drive_next;
        result.ready_res    = (step_next == ST_IDLE);
        result.done_res     = done;
        result.read_byte    = received_byte_next;
        result.ack_bit      = ack_store_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg          <= ST_IDLE;
            bit_index_reg     <= 4'd0;
            shift_byte_reg    <= 8'd0;
            wait_counter_reg  <= 16'd0;
            scl_drive_reg     <= 1'b0;
            sda_drive_reg     <= 1'b0;
            received_byte_reg <= 8'd0;
            ack_store_reg     <= 1'b1;
        end else if (tick_en) begin
            step_reg          <= step_next;
            bit_index_reg     <= bit_index_next;
            shift_byte_reg    <= shift_byte_next;
            wait_counter_reg  <= wait_counter_next;
            scl_drive_reg     <= scl_drive_next;
            sda_drive_reg     <= sda_drive_next;
            received_byte_reg <= received_byte_next;
            ack_store_reg     <= ack_store_next;
        end
    end

endmodule
